### hw/rtl/fwht_pkg.sv
// ----------------------------------------------------------------------------
// fwht_pkg
// Shared types and constants of the four-way aging hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package fwht_pkg;

  // fixed geometry
  localparam int WAYS = 4;
  localparam int WAY_IDX_W = 2;
  localparam int CLUSTER_INDEX_BITS_DEF = 10;
  localparam int CFG_W = 4;
  localparam logic [CFG_W-1:0] INDEX_BITS_RESET = 4'd10;

  // op codes
  localparam logic [1:0] OP_PROBE = 2'd0;
  localparam logic [1:0] OP_STORE = 2'd1;
  localparam logic [1:0] OP_NEW_SEARCH = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // bound code that marks an exact score
  localparam logic [1:0] BOUND_KIND_EXACT = 2'd3;

  // one stored entry
  typedef struct packed {
    logic               valid;
    logic [63:0]        key;
    logic [1:0]         bound;
    logic signed [7:0]  depth;
    logic [7:0]         age;
    logic [15:0]        move;
    logic signed [15:0] score;
    logic signed [15:0] eval;
  } way_t;

  // one cluster of ways, one memory row
  typedef way_t [WAYS-1:0] cluster_t;

  // lookup and replacement decision for one cluster
  typedef struct packed {
    logic                 hit;
    logic [WAY_IDX_W-1:0] hit_way;
    logic                 free_found;
    logic [WAY_IDX_W-1:0] target_way;
  } sel_t;

endpackage

`default_nettype wire

### hw/rtl/fwht_cluster_ram.sv
// ----------------------------------------------------------------------------
// fwht_cluster_ram
// Cluster memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fwht_cluster_ram
  import fwht_pkg::*;
#(
  parameter int ADDR_W = CLUSTER_INDEX_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire cluster_t          wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output cluster_t               rdata_o
);

  cluster_t mem [2**ADDR_W];
  cluster_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/fwht_way_select.sv
// ----------------------------------------------------------------------------
// fwht_way_select
// Key match over the four ways and choice of the way a store writes.
// ----------------------------------------------------------------------------
`default_nettype none

module fwht_way_select
  import fwht_pkg::*;
(
  input  wire cluster_t     cluster_i,
  input  wire logic [63:0]  key_i,
  input  wire logic [7:0]   cur_age_i,
  output sel_t              sel_o
);

  logic [WAYS-1:0] match;
  logic [WAYS-1:0] free_or_same;
  logic [WAY_IDX_W-1:0] rep_way;
  logic [WAY_IDX_W-1:0] cand;
  logic cand_cur;
  logic way_disc;
  logic shallower;

  // per-way compares
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      match[i] = cluster_i[i].valid && (cluster_i[i].key == key_i);
      free_or_same[i] = !cluster_i[i].valid || match[i];
    end
  end

  // first matching way, first free or same-key way
  always_comb begin
    sel_o.hit = 1'b0;
    sel_o.hit_way = '0;
    sel_o.free_found = 1'b0;
    sel_o.target_way = rep_way;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (match[i]) begin
        sel_o.hit = 1'b1;
        sel_o.hit_way = WAY_IDX_W'(i);
      end
      if (free_or_same[i]) begin
        sel_o.free_found = 1'b1;
        sel_o.target_way = WAY_IDX_W'(i);
      end
    end
  end

  // replacement chain over occupied ways, way 0 starts as candidate
  always_comb begin
    cand = '0;
    cand_cur = 1'b0;
    way_disc = 1'b0;
    shallower = 1'b0;
    for (int i = 1; i < WAYS; i++) begin
      cand_cur = (cluster_i[cand].age == cur_age_i);
      way_disc = (cluster_i[i].age == cur_age_i) || (cluster_i[i].bound == BOUND_KIND_EXACT);
      shallower = (cluster_i[i].depth < cluster_i[cand].depth);
      if ((cand_cur && !way_disc) || (cand_cur == way_disc && shallower)) begin
        cand = WAY_IDX_W'(i);
      end
    end
    rep_way = cand;
  end

endmodule

`default_nettype wire

### hw/rtl/four_way_hash_table_with_aging_core.sv
// ----------------------------------------------------------------------------
// four_way_hash_table_with_aging_core
// Four-way set-associative hash table with generation aging.
// ----------------------------------------------------------------------------
// Each item first issues the cluster read in its transfer cycle; the look
// state then compares the four ways, decides the replacement, writes a store's
// cluster back through the single memory write port and loads the result
// register. A result waiting downstream stalls the look state only. A clear
// item, after its look state, and reset run a sweep that writes one cluster a
// cycle over all 2**CLUSTER_INDEX_BITS clusters (1024 by default), during
// which no item transfer is taken; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module four_way_hash_table_with_aging_core
  import fwht_pkg::*;
#(
  parameter int CLUSTER_INDEX_BITS = CLUSTER_INDEX_BITS_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // configuration: index_bits_used
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [3:0]   cfg_wdata_i,
  // input items
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // key[63:0] bound_kind[65:64] search_depth[73:66] score_value[89:74]
  // static_eval[105:90] best_move[121:106], zero fill
  input  wire logic [127:0] s_axis_tdata_i,
  // op[1:0]
  input  wire logic [1:0]   s_axis_tuser_i,
  // results
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // found_bound[1:0] found_depth[9:2] found_score[25:10] found_eval[41:26]
  // found_move[57:42] found_age[65:58], zero fill
  output logic [71:0]       m_axis_tdata_o,
  // hit[0]
  output logic              m_axis_tuser_o
);

  localparam int AW = CLUSTER_INDEX_BITS;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_LOOK = 2'd2;

  logic [1:0] state_q, state_d;
  logic [AW-1:0] sweep_q, sweep_d;
  logic [CFG_W-1:0] index_bits_q;
  logic [7:0] age_q, age_d;
  logic out_valid_q, out_valid_d;
  logic out_hit_q;
  logic [65:0] out_data_q;

  // latched item
  logic [1:0] op_q;
  logic [63:0] key_q;
  logic [1:0] bound_q;
  logic [7:0] depth_q;
  logic [15:0] score_q;
  logic [15:0] eval_q;
  logic [15:0] move_q;
  logic [AW-1:0] idx_q;

  logic in_xfer;
  logic complete;
  logic [AW-1:0] in_idx;
  logic ram_we;
  logic [AW-1:0] ram_waddr;
  cluster_t ram_wdata;
  cluster_t rdata;
  cluster_t upd_cluster;
  way_t new_way;
  way_t hit_entry;
  sel_t sel;

  assign cfg_ready_o = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;
  assign complete = (state_q == ST_LOOK) && (!out_valid_q || m_axis_tready_i);

  // cluster index: key masked to the used bits, saturating at the table size
  always_comb begin
    for (int i = 0; i < AW; i++) begin
      in_idx[i] = s_axis_tdata_i[i] && (32'(index_bits_q) > 32'(i));
    end
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_bits_q <= INDEX_BITS_RESET;
    end else if (cfg_valid_i) begin
      index_bits_q <= cfg_wdata_i;
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q <= s_axis_tuser_i;
      key_q <= s_axis_tdata_i[63:0];
      bound_q <= s_axis_tdata_i[65:64];
      depth_q <= s_axis_tdata_i[73:66];
      score_q <= s_axis_tdata_i[89:74];
      eval_q <= s_axis_tdata_i[105:90];
      move_q <= s_axis_tdata_i[121:106];
      idx_q <= in_idx;
    end
  end

  fwht_cluster_ram #(
    .ADDR_W(AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (in_xfer),
    .raddr_i(in_idx),
    .rdata_o(rdata)
  );

  fwht_way_select u_sel (
    .cluster_i(rdata),
    .key_i    (key_q),
    .cur_age_i(age_q),
    .sel_o    (sel)
  );

  // entry written by a store
  always_comb begin
    new_way.valid = 1'b1;
    new_way.key = key_q;
    new_way.bound = bound_q;
    new_way.depth = depth_q;
    new_way.age = age_q;
    new_way.move = move_q;
    new_way.score = score_q;
    new_way.eval = eval_q;
    // zero move keeps the old move of an empty or same-key way
    if (move_q == 16'd0 && sel.free_found) begin
      new_way.move = rdata[sel.target_way].move;
    end
    upd_cluster = rdata;
    upd_cluster[sel.target_way] = new_way;
  end

  // memory write: clearing sweep or store write-back
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = upd_cluster;
    if (state_q == ST_CLEAR) begin
      ram_we = 1'b1;
      ram_waddr = sweep_q;
      ram_wdata = '0;
    end else if (complete && op_q == OP_STORE) begin
      ram_we = 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    sweep_d = sweep_q;
    age_d = age_q;
    case (state_q)
      ST_CLEAR: begin
        sweep_d = sweep_q + AW'(1);
        if (sweep_q == {AW{1'b1}}) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (complete) begin
          state_d = ST_IDLE;
          if (op_q == OP_NEW_SEARCH) begin
            age_d = age_q + 8'd1;
          end else if (op_q == OP_CLEAR) begin
            age_d = 8'd0;
            sweep_d = '0;
            state_d = ST_CLEAR;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      sweep_q <= '0;
      age_q <= 8'd0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      age_q <= age_d;
    end
  end

  // result register
  assign out_valid_d = (out_valid_q && !m_axis_tready_i) || complete;
  assign hit_entry = rdata[sel.hit_way];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (complete) begin
      if (op_q == OP_PROBE && sel.hit) begin
        out_hit_q <= 1'b1;
        out_data_q <= {hit_entry.age, hit_entry.move, hit_entry.eval,
                       hit_entry.score, hit_entry.depth, hit_entry.bound};
      end else begin
        out_hit_q <= 1'b0;
        out_data_q <= '0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o = out_hit_q;
  assign m_axis_tdata_o = {6'd0, out_data_q};

endmodule

`default_nettype wire
